### src/ktl_pkg.sv
// ktl_pkg: types, character codes, keyword tables and the token classifier
// shared by the keyword token lexer modules.
// No dependencies.
package ktl_pkg;

  // Transaction payloads
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_stream;
  } ktl_in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } ktl_out_t;

  // Token classes of the pending token
  localparam logic [1:0] CLASS_DIGIT = 2'd0;
  localparam logic [1:0] CLASS_IDENT = 2'd1;
  localparam logic [1:0] CLASS_OTHER = 2'd2;

  // Lexer state, one register each
  typedef struct packed {
    logic        in_token;
    logic [1:0]  token_class;
    logic [7:0]  first_char;
    logic [5:0]  keyword_hits;
    logic [15:0] pending_length;
    logic [31:0] pending_start;
    logic [31:0] char_position;
    logic        halted;
  } ktl_state_t;

  // Token kinds
  localparam logic [3:0] KIND_INT     = 4'd6;
  localparam logic [3:0] KIND_IDENT   = 4'd7;
  localparam logic [3:0] KIND_COLON   = 4'd8;
  localparam logic [3:0] KIND_PLUS    = 4'd9;
  localparam logic [3:0] KIND_STAR    = 4'd10;
  localparam logic [3:0] KIND_COMMA   = 4'd11;
  localparam logic [3:0] KIND_LPAREN  = 4'd12;
  localparam logic [3:0] KIND_RPAREN  = 4'd13;
  localparam logic [3:0] KIND_ASSIGN  = 4'd14;
  localparam logic [3:0] KIND_UNKNOWN = 4'd15;

  // Character codes
  localparam logic [7:0] CHAR_SPACE    = 8'd32;
  localparam logic [7:0] CHAR_DIGIT_LO = 8'd48;
  localparam logic [7:0] CHAR_DIGIT_HI = 8'd57;
  localparam logic [7:0] CHAR_UPPER_LO = 8'd65;
  localparam logic [7:0] CHAR_UPPER_HI = 8'd90;
  localparam logic [7:0] CHAR_LOWER_LO = 8'd97;
  localparam logic [7:0] CHAR_LOWER_HI = 8'd122;
  localparam logic [7:0] CHAR_COLON    = 8'h3A;
  localparam logic [7:0] CHAR_EQUALS   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS     = 8'h2B;
  localparam logic [7:0] CHAR_STAR     = 8'h2A;
  localparam logic [7:0] CHAR_COMMA    = 8'h2C;
  localparam logic [7:0] CHAR_LPAREN   = 8'h28;
  localparam logic [7:0] CHAR_RPAREN   = 8'h29;

  localparam logic [15:0] MAX_TOKEN_LEN = 16'hFFFF;

  // Keywords; index is the token kind. Rows padded with NUL to 8.
  localparam int KW_COUNT = 6;
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"B", "E", "G", "I", "N", 8'h00, 8'h00, 8'h00},
    '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"F", "O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"I", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"T", "H", "E", "N", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"E", "L", "S", "E", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [15:0] KW_LEN [KW_COUNT] = '{16'd5, 16'd3, 16'd3, 16'd2, 16'd4, 16'd4};

  // Kind of the pending token held in s
  function automatic logic [3:0] classify(input ktl_state_t s);
    logic [3:0] kind;
    logic       found;
    kind  = KIND_UNKNOWN;
    found = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!found && s.keyword_hits[k] && (s.pending_length == KW_LEN[k])) begin
        kind  = 4'(k);
        found = 1'b1;
      end
    end
    if (!found) begin
      case (s.token_class)
        CLASS_DIGIT: kind = KIND_INT;
        CLASS_IDENT: kind = KIND_IDENT;
        default: begin
          if (s.pending_length == 16'd1) begin
            case (s.first_char)
              CHAR_COLON:  kind = KIND_COLON;
              CHAR_PLUS:   kind = KIND_PLUS;
              CHAR_STAR:   kind = KIND_STAR;
              CHAR_COMMA:  kind = KIND_COMMA;
              CHAR_LPAREN: kind = KIND_LPAREN;
              CHAR_RPAREN: kind = KIND_RPAREN;
              default:     kind = KIND_UNKNOWN;
            endcase
          end else if (s.pending_length == 16'd2 && s.first_char == CHAR_COLON) begin
            kind = KIND_ASSIGN;
          end else begin
            kind = KIND_UNKNOWN;
          end
        end
      endcase
    end
    return kind;
  endfunction

endpackage

### src/ktl_step.sv
// ktl_step: next lexer state and up to two tokens for one character.
// Depends on ktl_pkg.
module ktl_step (
  input  ktl_pkg::ktl_state_t cur,
  input  ktl_pkg::ktl_in_t    item,
  input  logic                accept,
  output ktl_pkg::ktl_state_t nxt,
  output ktl_pkg::ktl_out_t   res0,
  output ktl_pkg::ktl_out_t   res1,
  output logic [1:0]          res_count
);

  logic [7:0]          c;
  logic                sep, is_digit, is_letter, joins;
  logic                flush_a, halt_a, start_tok, extend, flush_b;
  logic [3:0]          kind_a, kind_b;
  logic [5:0]          hits_begin, hits_keep;
  ktl_pkg::ktl_state_t mid;
  ktl_pkg::ktl_out_t   res_a, res_b;

  assign c         = item.char_byte;
  assign sep       = (c <= ktl_pkg::CHAR_SPACE) || c[7];
  assign is_digit  = (c >= ktl_pkg::CHAR_DIGIT_LO) && (c <= ktl_pkg::CHAR_DIGIT_HI);
  assign is_letter = ((c >= ktl_pkg::CHAR_UPPER_LO) && (c <= ktl_pkg::CHAR_UPPER_HI)) ||
                     ((c >= ktl_pkg::CHAR_LOWER_LO) && (c <= ktl_pkg::CHAR_LOWER_HI));

  always_comb begin
    case (cur.token_class)
      ktl_pkg::CLASS_DIGIT: joins = is_digit;
      ktl_pkg::CLASS_IDENT: joins = is_digit || is_letter;
      default: joins = (cur.first_char == ktl_pkg::CHAR_COLON) &&
                       (cur.pending_length == 16'd1) && (c == ktl_pkg::CHAR_EQUALS);
    endcase
  end

  // incremental keyword match
  always_comb begin
    for (int k = 0; k < ktl_pkg::KW_COUNT; k++) begin
      hits_begin[k] = (ktl_pkg::KW_TEXT[k][0] == c);
      hits_keep[k]  = (cur.pending_length < ktl_pkg::KW_LEN[k]) &&
                      (ktl_pkg::KW_TEXT[k][cur.pending_length[2:0]] == c);
    end
  end

  assign kind_a    = ktl_pkg::classify(cur);
  assign flush_a   = cur.in_token && (sep || !joins);
  assign halt_a    = flush_a && (kind_a == ktl_pkg::KIND_UNKNOWN);
  assign start_tok = !sep && (!cur.in_token || !joins) && !halt_a;
  assign extend    = cur.in_token && !sep && joins;

  always_comb begin
    mid = cur;
    mid.char_position = item.end_of_stream ? 32'd0 : cur.char_position + 32'd1;
    if (flush_a) begin
      mid.in_token = 1'b0;
      mid.halted   = halt_a;
    end
    if (start_tok) begin
      mid.in_token       = 1'b1;
      mid.token_class    = is_digit ? ktl_pkg::CLASS_DIGIT :
                           (is_letter ? ktl_pkg::CLASS_IDENT : ktl_pkg::CLASS_OTHER);
      mid.first_char     = c;
      mid.pending_length = 16'd1;
      mid.pending_start  = cur.char_position;
      mid.keyword_hits   = hits_begin;
    end
    if (extend) begin
      mid.keyword_hits   = cur.keyword_hits & hits_keep;
      mid.pending_length = (cur.pending_length != ktl_pkg::MAX_TOKEN_LEN) ?
                           cur.pending_length + 16'd1 : cur.pending_length;
    end
  end

  assign kind_b  = ktl_pkg::classify(mid);
  assign flush_b = item.end_of_stream && mid.in_token;

  always_comb begin
    res_a.token_kind   = kind_a;
    res_a.token_start  = cur.pending_start;
    res_a.token_length = cur.pending_length;
    res_a.last_of_run  = !flush_b;
    res_b.token_kind   = kind_b;
    res_b.token_start  = mid.pending_start;
    res_b.token_length = mid.pending_length;
    res_b.last_of_run  = 1'b1;

    nxt = mid;
    if (flush_b) begin
      nxt.in_token = 1'b0;
      nxt.halted   = (kind_b == ktl_pkg::KIND_UNKNOWN);
    end

    res0      = flush_a ? res_a : res_b;
    res1      = res_b;
    res_count = {1'b0, flush_a} + {1'b0, flush_b};

    // halted block swallows characters
    if (!accept || cur.halted) begin
      nxt       = cur;
      res_count = 2'd0;
    end
  end

endmodule

### src/ktl_result_fifo.sv
// ktl_result_fifo: four-entry token queue, up to two pushes and one pop
// per cycle. Depends on ktl_pkg.
module ktl_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  ktl_pkg::ktl_out_t push0,
  input  ktl_pkg::ktl_out_t push1,
  input  logic [1:0]        push_count,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output ktl_pkg::ktl_out_t out_data
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  ktl_pkg::ktl_out_t    entries [DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [PTR_W:0]       count, count_next;
  logic                 pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != '0);
  assign out_data   = entries[rd_ptr];
  // two free slots needed for the worst case of one character
  assign room       = (count <= (PTR_W+1)'(DEPTH - 2));
  assign count_next = count + (PTR_W+1)'(push_count) - (PTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push1;
    end
  end

endmodule

### src/keyword_token_lexer_unit.sv
// keyword_token_lexer_unit: byte-serial tokenizer with keyword classification.
// Depends on ktl_pkg, ktl_step and ktl_result_fifo.
//
// One character byte is taken per transaction, and the block can take one in
// every clock cycle. Whitespace and control bytes (0..32) and bytes 128..255
// separate tokens. A token is a digit run, an identifier (letter then letters
// or digits), ":=" or any other single character. Each finished token comes
// out as one result transaction carrying its kind (BEGIN, END, FOR, IF, THEN,
// ELSE, Int, Ident, seven punctuators, Unknown), the stream position of its
// first character and its length, which saturates at 65535. A character
// yields zero, one or two results: the token it ends and, when it carries
// end_of_stream, the pending token flushed at the end; last_of_run marks the
// final one. The next character after end_of_stream is position 0. Keywords
// are matched as the characters arrive, one hit bit per keyword, so
// classification is a short compare. The lexer state is updated in the
// cycle a character is accepted and its results are in the output queue
// the next cycle. The four-entry result queue decouples the sides; in_ready
// drops only while fewer than two queue slots are free, so with a ready sink
// the rate is one character per cycle. After an Unknown token the block
// halts: characters are still accepted but give no results until reset.
module keyword_token_lexer_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ktl_pkg::ktl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ktl_pkg::ktl_out_t out_data
);

  ktl_pkg::ktl_state_t state, state_next;
  ktl_pkg::ktl_out_t   res0, res1;
  logic [1:0]          res_count;
  logic                accept;
  logic                room;

  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  // lexer state: in_token, class, first char, keyword hits, pending token,
  // stream position and halt flag; all reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else begin
      state <= state_next;
    end
  end

  ktl_step u_step (
    .cur       (state),
    .item      (in_data),
    .accept    (accept),
    .nxt       (state_next),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  // finished tokens wait here for the sink
  ktl_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push0      (res0),
    .push1      (res1),
    .push_count (res_count),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### dv/keyword_token_lexer_unit_test.sv
// keyword_token_lexer_unit_test: self-checking bench for the byte-serial keyword lexer.
// Drives character transactions, predicts every token in-bench and scores results in order.
// Depends on ktl_pkg and keyword_token_lexer_unit.
module keyword_token_lexer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Keyword kinds are the keyword's index in the table below
  localparam logic [3:0] KIND_BEGIN = 4'd0;
  localparam logic [3:0] KIND_FOR   = 4'd2;
  localparam logic [3:0] KIND_IF    = 4'd3;

  // Keyword spellings, right-justified in 40 bits
  localparam int         KW_NUM = 6;
  localparam logic [39:0] KW_WORD [KW_NUM] = '{"BEGIN", "END", "FOR", "IF", "THEN", "ELSE"};
  localparam int          KW_SIZE [KW_NUM] = '{5, 3, 3, 2, 4, 4};

  localparam logic [7:0] PUNCT_CHARS [6] = '{ktl_pkg::CHAR_COLON, ktl_pkg::CHAR_PLUS,
                                             ktl_pkg::CHAR_STAR, ktl_pkg::CHAR_COMMA,
                                             ktl_pkg::CHAR_LPAREN, ktl_pkg::CHAR_RPAREN};

  localparam logic [15:0] LEN_SAT          = 16'hFFFF;
  localparam int          LONG_TOKEN_CHARS = 48;     // well past every keyword length
  localparam int          PHASE_ITEMS      = 250;
  localparam int          HOLD_CYCLES      = 300;    // long receiver hold-off
  localparam int          DRAIN_CYCLES     = 8;      // margin after the last awaited token
  localparam int          STUCK_LIMIT      = 3000;   // cycles with no transaction on either side
  localparam int          REPORT_MAX       = 10;

  // Predicted lexer state
  typedef struct packed {
    logic        open;      // a token is pending
    logic [1:0]  cls;
    logic [7:0]  lead;      // first character of the pending token
    logic [5:0]  hits;      // keywords still matching
    logic [15:0] len;
    logic [31:0] start;
    logic [31:0] pos;
    logic        halted;
  } lex_state_t;

  // One directed transaction; tok is only meaningful when typed is set
  typedef struct packed {
    logic [7:0]        ch;
    logic              eos;
    logic              typed;
    ktl_pkg::ktl_out_t tok;
  } lex_row_t;

  localparam ktl_pkg::ktl_out_t NO_TOKEN = '0;

  // Directed stream. Positions restart at 0 after each end-of-stream row.
  localparam lex_row_t DIRECTED [25] = '{
    '{"B",   1'b0, 1'b0, NO_TOKEN},
    '{"E",   1'b0, 1'b0, NO_TOKEN},
    '{"G",   1'b0, 1'b0, NO_TOKEN},
    '{"I",   1'b0, 1'b0, NO_TOKEN},
    '{"N",   1'b0, 1'b0, NO_TOKEN},
    '{8'hFF, 1'b0, 1'b1, '{KIND_BEGIN, 32'd0, 16'd5, 1'b1}},  // top byte separates
    '{"9",   1'b0, 1'b0, NO_TOKEN},
    '{"x",   1'b0, 1'b1, '{ktl_pkg::KIND_INT, 32'd6, 16'd1, 1'b1}},  // letter ends a digit run
    '{":",   1'b0, 1'b1, '{ktl_pkg::KIND_IDENT, 32'd7, 16'd1, 1'b1}},
    '{"=",   1'b0, 1'b0, NO_TOKEN},
    '{"(",   1'b0, 1'b1, '{ktl_pkg::KIND_ASSIGN, 32'd8, 16'd2, 1'b1}},
    '{")",   1'b0, 1'b1, '{ktl_pkg::KIND_LPAREN, 32'd10, 16'd1, 1'b1}},
    '{"+",   1'b0, 1'b1, '{ktl_pkg::KIND_RPAREN, 32'd11, 16'd1, 1'b1}},
    '{"*",   1'b0, 1'b1, '{ktl_pkg::KIND_PLUS, 32'd12, 16'd1, 1'b1}},
    '{",",   1'b0, 1'b1, '{ktl_pkg::KIND_STAR, 32'd13, 16'd1, 1'b1}},
    '{"I",   1'b0, 1'b1, '{ktl_pkg::KIND_COMMA, 32'd14, 16'd1, 1'b1}},
    '{"F",   1'b1, 1'b1, '{KIND_IF, 32'd15, 16'd2, 1'b1}},  // flushed by end of stream
    '{"F",   1'b0, 1'b0, NO_TOKEN},
    '{"O",   1'b0, 1'b0, NO_TOKEN},
    '{"R",   1'b1, 1'b1, '{KIND_FOR, 32'd0, 16'd3, 1'b1}},
    '{"T",   1'b0, 1'b0, NO_TOKEN},
    '{"H",   1'b0, 1'b0, NO_TOKEN},
    '{"E",   1'b0, 1'b0, NO_TOKEN},
    '{"N",   1'b0, 1'b0, NO_TOKEN},
    '{":",   1'b1, 1'b0, NO_TOKEN}    // two results: THEN, then the flushed colon
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  ktl_pkg::ktl_in_t  feed = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ktl_pkg::ktl_out_t out_data;

  // Side-band travelling with the current input transaction
  logic              row_typed = 1'b0;
  ktl_pkg::ktl_out_t row_tok = '0;

  lex_state_t        lx = '0;          // matches the block's reset state
  ktl_pkg::ktl_out_t step_tokens[$];   // tokens caused by the transaction just taken
  ktl_pkg::ktl_out_t tokens_due[$];    // tokens still awaited from the block

  int faults = 0;
  int items_sent = 0;
  int stuck_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;

  keyword_token_lexer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (feed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_digit(input logic [7:0] c);
    return c >= ktl_pkg::CHAR_DIGIT_LO && c <= ktl_pkg::CHAR_DIGIT_HI;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= ktl_pkg::CHAR_UPPER_LO && c <= ktl_pkg::CHAR_UPPER_HI) ||
           (c >= ktl_pkg::CHAR_LOWER_LO && c <= ktl_pkg::CHAR_LOWER_HI);
  endfunction

  // Character p of keyword k, counted from the left
  function automatic logic [7:0] kw_char(input int k, input int p);
    return KW_WORD[k][8*(KW_SIZE[k]-1-p) +: 8];
  endfunction

  function automatic void open_token(input logic [7:0] c, input logic [31:0] p);
    lx.open  = 1'b1;
    lx.cls   = is_digit(c) ? ktl_pkg::CLASS_DIGIT :
               (is_letter(c) ? ktl_pkg::CLASS_IDENT : ktl_pkg::CLASS_OTHER);
    lx.lead  = c;
    lx.len   = 16'd1;
    lx.start = p;
    lx.hits  = '0;
    for (int k = 0; k < KW_NUM; k++)
      if (kw_char(k, 0) == c) lx.hits[k] = 1'b1;
  endfunction

  // Classify and emit the pending token; an Unknown one halts the lexer
  function automatic void close_token();
    logic [3:0]        kind;
    bit                found;
    ktl_pkg::ktl_out_t t;
    kind  = ktl_pkg::KIND_UNKNOWN;
    found = 1'b0;
    for (int k = 0; k < KW_NUM; k++) begin
      if (!found && lx.hits[k] && int'(lx.len) == KW_SIZE[k]) begin
        kind  = 4'(k);
        found = 1'b1;
      end
    end
    if (!found) begin
      if (lx.cls == ktl_pkg::CLASS_DIGIT) begin
        kind = ktl_pkg::KIND_INT;
      end else if (lx.cls == ktl_pkg::CLASS_IDENT) begin
        kind = ktl_pkg::KIND_IDENT;
      end else if (lx.len == 16'd1) begin
        case (lx.lead)
          ktl_pkg::CHAR_COLON:  kind = ktl_pkg::KIND_COLON;
          ktl_pkg::CHAR_PLUS:   kind = ktl_pkg::KIND_PLUS;
          ktl_pkg::CHAR_STAR:   kind = ktl_pkg::KIND_STAR;
          ktl_pkg::CHAR_COMMA:  kind = ktl_pkg::KIND_COMMA;
          ktl_pkg::CHAR_LPAREN: kind = ktl_pkg::KIND_LPAREN;
          ktl_pkg::CHAR_RPAREN: kind = ktl_pkg::KIND_RPAREN;
          default:              kind = ktl_pkg::KIND_UNKNOWN;
        endcase
      end else if (lx.len == 16'd2 && lx.lead == ktl_pkg::CHAR_COLON) begin
        kind = ktl_pkg::KIND_ASSIGN;
      end
    end
    t.token_kind   = kind;
    t.token_start  = lx.start;
    t.token_length = lx.len;
    t.last_of_run  = 1'b0;
    step_tokens.push_back(t);
    lx.open = 1'b0;
    if (kind == ktl_pkg::KIND_UNKNOWN) lx.halted = 1'b1;
  endfunction

  // Advance the predicted lexer by one character; results land in step_tokens
  function automatic void lex_step(input logic [7:0] c, input logic eos);
    logic [31:0] p;
    bit          joins;
    step_tokens.delete();
    if (lx.halted) return;
    p      = lx.pos;
    lx.pos = eos ? 32'd0 : p + 32'd1;
    if (c <= ktl_pkg::CHAR_SPACE || c[7]) begin
      if (lx.open) close_token();
    end else if (lx.open) begin
      if (lx.cls == ktl_pkg::CLASS_DIGIT)
        joins = is_digit(c);
      else if (lx.cls == ktl_pkg::CLASS_IDENT)
        joins = is_digit(c) || is_letter(c);
      else
        joins = lx.lead == ktl_pkg::CHAR_COLON && lx.len == 16'd1 &&
                c == ktl_pkg::CHAR_EQUALS;
      if (joins) begin
        for (int k = 0; k < KW_NUM; k++)
          if (!(int'(lx.len) < KW_SIZE[k] && kw_char(k, int'(lx.len)) == c))
            lx.hits[k] = 1'b0;
        if (lx.len != LEN_SAT) lx.len = lx.len + 16'd1;
      end else begin
        close_token();
        if (!lx.halted) open_token(c, p);
      end
    end else begin
      open_token(c, p);
    end
    if (eos && lx.open && !lx.halted) close_token();
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard and watchdog. Outputs are scored before the input of the same
  // edge is predicted, so a token can never be matched against its own future.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    ktl_pkg::ktl_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          if (faults < REPORT_MAX)
            $display("%0t: token with none awaited: kind %0d start %0d len %0d last %0d",
                     $realtime, out_data.token_kind, out_data.token_start,
                     out_data.token_length, out_data.last_of_run);
          faults++;
        end else begin
          want = tokens_due.pop_front();
          if (out_data.token_kind !== want.token_kind ||
              out_data.token_start !== want.token_start ||
              out_data.token_length !== want.token_length ||
              out_data.last_of_run !== want.last_of_run) begin
            if (faults < REPORT_MAX)
              $display("%0t: token mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d %s",
                       $realtime, want.token_kind, want.token_start, want.token_length,
                       want.last_of_run, out_data.token_kind, out_data.token_start,
                       out_data.token_length, out_data.last_of_run, "(kind/start/len/last)");
            faults++;
          end
        end
      end
      if (in_valid && in_ready) begin
        lex_step(feed.char_byte, feed.end_of_stream);
        if (row_typed)
          tokens_due.push_back(row_tok);
        else
          foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, STUCK_LIMIT);
        $display("keyword_token_lexer_unit_test: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink. A long hold-off is counted here, started by a request count
  // from the stimulus process, so the sender keeps offering meanwhile.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    static int holds_served = 0;
    static int hold_left = 0;
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Character source
  // ---------------------------------------------------------------------------

  // Offer one character transaction and hold it until taken
  task automatic offer(input logic [7:0] ch, input logic eos,
                       input logic typed, input ktl_pkg::ktl_out_t tok);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    feed.char_byte     = ch;
    feed.end_of_stream = eos;
    row_typed          = typed;
    row_tok            = tok;
    in_valid           = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every awaited token has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_letter();
    return $urandom_range(1) ?
           8'($urandom_range(ktl_pkg::CHAR_UPPER_LO, ktl_pkg::CHAR_UPPER_HI)) :
           8'($urandom_range(ktl_pkg::CHAR_LOWER_LO, ktl_pkg::CHAR_LOWER_HI));
  endfunction

  function automatic logic [7:0] random_digit();
    return 8'($urandom_range(ktl_pkg::CHAR_DIGIT_LO, ktl_pkg::CHAR_DIGIT_HI));
  endfunction

  function automatic logic [7:0] random_word_char();
    return ($urandom_range(3) == 0) ? random_digit() : random_letter();
  endfunction

  function automatic logic [7:0] separator_byte();
    return $urandom_range(1) ? 8'($urandom_range(32)) : 8'($urandom_range(128, 255));
  endfunction

  // One lexeme, mostly well formed, optionally followed by a separator.
  // Nothing here can form an Unknown token: '=' only ever follows ':'.
  task automatic send_lexeme();
    logic [7:0] text[$];
    logic [7:0] c;
    int         pick;
    int         k;
    bit         known;
    bit         eos;
    pick = $urandom_range(99);
    k    = $urandom_range(KW_NUM - 1);
    if (pick < 30) begin
      for (int i = 0; i < KW_SIZE[k]; i++) text.push_back(kw_char(k, i));
      // near misses: lower case, short, long, one letter in the wrong case
      if (pick >= 20) begin
        case ($urandom_range(3))
          0:       foreach (text[i]) text[i] = text[i] | 8'h20;
          1:       void'(text.pop_back());
          2:       text.push_back(random_word_char());
          default: begin
            c = 8'($urandom_range(text.size() - 1));
            text[c] = text[c] ^ 8'h20;
          end
        endcase
      end
    end else if (pick < 50) begin
      text.push_back(random_letter());
      repeat ($urandom_range(7)) text.push_back(random_word_char());
    end else if (pick < 65) begin
      repeat ($urandom_range(1, 6)) text.push_back(random_digit());
    end else if (pick < 80) begin
      text.push_back(PUNCT_CHARS[$urandom_range(5)]);
    end else if (pick < 88) begin
      text.push_back(ktl_pkg::CHAR_COLON);
      text.push_back(ktl_pkg::CHAR_EQUALS);
    end else begin
      // noise: any byte, with the ones that would halt the lexer swapped out
      repeat ($urandom_range(1, 4)) begin
        c     = 8'($urandom_range(255));
        known = is_digit(c) || is_letter(c) || c <= ktl_pkg::CHAR_SPACE || c[7];
        foreach (PUNCT_CHARS[j]) if (PUNCT_CHARS[j] == c) known = 1'b1;
        text.push_back(known ? c : separator_byte());
      end
    end
    if ($urandom_range(9) < 6) text.push_back(separator_byte());
    eos = ($urandom_range(24) == 0);
    foreach (text[i]) offer(text[i], eos && (i == text.size() - 1), 1'b0, NO_TOKEN);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int target;
    bit hold_armed;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: keywords, every punctuator, a separator from the top byte range,
    // end of stream flushing one and two tokens
    foreach (DIRECTED[i])
      offer(DIRECTED[i].ch, DIRECTED[i].eos, DIRECTED[i].typed, DIRECTED[i].tok);

    // Long identifier
    offer("Q", 1'b0, 1'b0, NO_TOKEN);
    repeat (LONG_TOKEN_CHARS - 1) offer(random_word_char(), 1'b0, 1'b0, NO_TOKEN);
    offer(ktl_pkg::CHAR_SPACE, 1'b0, 1'b0, NO_TOKEN);
    wait_drained();

    // Random lexemes under four idling patterns; the sender drains after each
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 82;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 82;
        end
        default: begin
          send_idle_pct = 36;
          stall_pct     = 36;
        end
      endcase
      target     = items_sent + PHASE_ITEMS;
      hold_armed = (ph == 0);
      while (items_sent < target) begin
        // sink holds off while the source streams at full rate: queue fills
        if (hold_armed && items_sent >= target - PHASE_ITEMS / 2) begin
          hold_requests++;
          hold_armed = 1'b0;
        end
        send_lexeme();
      end
      wait_drained();
    end

    // Halt: a lone '!' is Unknown, the letter ending it is dropped and every
    // later transaction is taken without results
    send_idle_pct = 0;
    stall_pct     = 36;
    offer("!", 1'b0, 1'b0, NO_TOKEN);
    offer("A", 1'b0, 1'b0, NO_TOKEN);
    offer("7", 1'b0, 1'b0, NO_TOKEN);
    offer(ktl_pkg::CHAR_SPACE, 1'b0, 1'b0, NO_TOKEN);
    offer("+", 1'b1, 1'b0, NO_TOKEN);
    wait_drained();

    if (faults == 0 && tokens_due.size() == 0)
      $display("keyword_token_lexer_unit_test: clean");
    else
      $display("keyword_token_lexer_unit_test: errors");
    $finish;
  end

endmodule
